// File: rtl/scancode_to_char_translator_defines.svh
// assertion helpers shared by the translator modules
`ifndef SCANCODE_TO_CHAR_TRANSLATOR_DEFINES_SVH
`define SCANCODE_TO_CHAR_TRANSLATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SC2C_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sc2c assertion failed");

// next-cycle implication, disabled while in reset
`define SC2C_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sc2c assertion failed");

`endif

// File: rtl/sc2c_pkg.sv
package sc2c_pkg;

  localparam int ByteW = 8;
  localparam int IdxW  = 7;

  localparam int BreakBit = 7;

  // modifier scancodes (make form)
  localparam logic [ByteW-1:0] KEY_LSHIFT = 8'h2A;
  localparam logic [ByteW-1:0] KEY_RSHIFT = 8'h36;
  localparam logic [ByteW-1:0] KEY_ALT    = 8'h38;
  localparam logic [ByteW-1:0] KEY_CAPS   = 8'h3A;

  localparam logic [ByteW-1:0] CEDILLA_LO = 8'h87;
  localparam logic [ByteW-1:0] LETTER_A   = 8'h61;
  localparam logic [ByteW-1:0] LETTER_Z   = 8'h7A;
  localparam logic [ByteW-1:0] NO_CHAR    = 8'h00;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef struct packed {
    logic shift;
    logic caps;
    logic alt;
  } sc2c_flags_t;

  // abnt2 layout, unshifted
  function automatic byte_t rom_normal(input idx_t idx);
    byte_t r;
    unique case (idx)
      7'd1:   r = 8'h1B;
      7'd2:   r = 8'h31;
      7'd3:   r = 8'h32;
      7'd4:   r = 8'h33;
      7'd5:   r = 8'h34;
      7'd6:   r = 8'h35;
      7'd7:   r = 8'h36;
      7'd8:   r = 8'h37;
      7'd9:   r = 8'h38;
      7'd10:  r = 8'h39;
      7'd11:  r = 8'h30;
      7'd12:  r = 8'h2D;
      7'd13:  r = 8'h3D;
      7'd14:  r = 8'h08;
      7'd15:  r = 8'h09;
      7'd16:  r = 8'h71;
      7'd17:  r = 8'h77;
      7'd18:  r = 8'h65;
      7'd19:  r = 8'h72;
      7'd20:  r = 8'h74;
      7'd21:  r = 8'h79;
      7'd22:  r = 8'h75;
      7'd23:  r = 8'h69;
      7'd24:  r = 8'h6F;
      7'd25:  r = 8'h70;
      7'd26:  r = 8'h60;
      7'd27:  r = 8'h5B;
      7'd28:  r = 8'h0A;
      7'd30:  r = 8'h61;
      7'd31:  r = 8'h73;
      7'd32:  r = 8'h64;
      7'd33:  r = 8'h66;
      7'd34:  r = 8'h67;
      7'd35:  r = 8'h68;
      7'd36:  r = 8'h6A;
      7'd37:  r = 8'h6B;
      7'd38:  r = 8'h6C;
      7'd39:  r = 8'h87;
      7'd40:  r = 8'h7E;
      7'd41:  r = 8'h27;
      7'd43:  r = 8'h5D;
      7'd44:  r = 8'h7A;
      7'd45:  r = 8'h78;
      7'd46:  r = 8'h63;
      7'd47:  r = 8'h76;
      7'd48:  r = 8'h62;
      7'd49:  r = 8'h6E;
      7'd50:  r = 8'h6D;
      7'd51:  r = 8'h2C;
      7'd52:  r = 8'h2E;
      7'd53:  r = 8'h3B;
      7'd55:  r = 8'h2A;
      7'd57:  r = 8'h20;
      7'd80:  r = 8'h2D;
      7'd84:  r = 8'h2B;
      7'd92:  r = 8'h5C;
      7'd106: r = 8'h2F;
      default: r = NO_CHAR;
    endcase
    return r;
  endfunction

  // abnt2 layout, shifted
  function automatic byte_t rom_shift(input idx_t idx);
    byte_t r;
    unique case (idx)
      7'd1:   r = 8'h1B;
      7'd2:   r = 8'h21;
      7'd3:   r = 8'h40;
      7'd4:   r = 8'h23;
      7'd5:   r = 8'h24;
      7'd6:   r = 8'h25;
      7'd7:   r = 8'h9B;
      7'd8:   r = 8'h26;
      7'd9:   r = 8'h2A;
      7'd10:  r = 8'h28;
      7'd11:  r = 8'h29;
      7'd12:  r = 8'h5F;
      7'd13:  r = 8'h2B;
      7'd14:  r = 8'h08;
      7'd15:  r = 8'h09;
      7'd16:  r = 8'h51;
      7'd17:  r = 8'h57;
      7'd18:  r = 8'h45;
      7'd19:  r = 8'h52;
      7'd20:  r = 8'h54;
      7'd21:  r = 8'h59;
      7'd22:  r = 8'h55;
      7'd23:  r = 8'h49;
      7'd24:  r = 8'h4F;
      7'd25:  r = 8'h50;
      7'd26:  r = 8'h5E;
      7'd27:  r = 8'h7B;
      7'd28:  r = 8'h0A;
      7'd30:  r = 8'h41;
      7'd31:  r = 8'h53;
      7'd32:  r = 8'h44;
      7'd33:  r = 8'h46;
      7'd34:  r = 8'h47;
      7'd35:  r = 8'h48;
      7'd36:  r = 8'h4A;
      7'd37:  r = 8'h4B;
      7'd38:  r = 8'h4C;
      7'd39:  r = 8'h80;
      7'd40:  r = 8'h5E;
      7'd41:  r = 8'h22;
      7'd43:  r = 8'h7D;
      7'd44:  r = 8'h5A;
      7'd45:  r = 8'h58;
      7'd46:  r = 8'h43;
      7'd47:  r = 8'h56;
      7'd48:  r = 8'h42;
      7'd49:  r = 8'h4E;
      7'd50:  r = 8'h4D;
      7'd51:  r = 8'h3C;
      7'd52:  r = 8'h3E;
      7'd53:  r = 8'h3A;
      7'd55:  r = 8'h2A;
      7'd57:  r = 8'h20;
      7'd80:  r = 8'h2D;
      7'd84:  r = 8'h2B;
      7'd92:  r = 8'h7C;
      7'd106: r = 8'h3F;
      default: r = NO_CHAR;
    endcase
    return r;
  endfunction

  // alt-gr style symbols
  function automatic byte_t rom_alt(input idx_t idx);
    byte_t r;
    unique case (idx)
      7'd2:   r = 8'hFD;
      7'd3:   r = 8'hFD;
      7'd4:   r = 8'hFD;
      7'd5:   r = 8'h9C;
      7'd6:   r = 8'hBD;
      7'd7:   r = 8'hAA;
      7'd13:  r = 8'h15;
      7'd27:  r = 8'hA6;
      7'd43:  r = 8'hA7;
      7'd106: r = 8'hF8;
      default: r = NO_CHAR;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/sc2c_scan_if.sv
interface sc2c_scan_if;
  import sc2c_pkg::*;

  logic  valid;
  logic  ready;
  byte_t scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

// File: rtl/sc2c_char_if.sv
interface sc2c_char_if;
  import sc2c_pkg::*;

  logic  valid;
  logic  ready;
  byte_t char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

// File: rtl/scancode_to_char_translator.sv
// set-1 scancode to character translator, abnt2 layout
// in_scan: one scancode byte per request (valid/ready); bit 7 marks a key release
// out_char: one character byte per scancode, 0 when the byte gives no character
// (release codes, modifier keys, prefix bytes, unmapped keys)
// shift, alt and caps lock are tracked inside; they follow the requests in order
// a byte accepted on in_scan passes the input register, then the result register, to out_char
// throughput: one request per cycle while out_char takes each result; the rom lookup
// sits between the input register and the result register
// reset: synchronous, active low; clears both stages and all three modifier flags
// stall: when out_char is not taken the result holds, the input register still
// takes one more byte, then in_scan.ready drops until the result moves on
`include "scancode_to_char_translator_defines.svh"

module scancode_to_char_translator (
  input logic        clk,
  input logic        rst_n,
  sc2c_scan_if.sink  in_scan,
  sc2c_char_if.source out_char
);
  import sc2c_pkg::*;

  // input register stage
  logic        s1_valid_r;
  byte_t       s1_byte_r;
  // result register stage
  logic        out_valid_r;
  byte_t       out_char_r;

  sc2c_flags_t flags;
  byte_t       char_nxt;
  logic        out_free;
  logic        s1_fire;
  logic        in_fire;

  // result slot frees up when empty or being taken this cycle
  assign out_free = !out_valid_r || out_char.ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_scan.ready = !s1_valid_r || out_free;
  assign in_fire  = in_scan.valid && in_scan.ready;

  // modifier flags advance exactly when a byte leaves the input register
  sc2c_modifiers u_mods (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (s1_fire),
    .scan_byte (s1_byte_r),
    .flags     (flags)
  );

  // rom lookup with the flags as they stand before this byte
  sc2c_xlate u_xlate (
    .scan_byte (s1_byte_r),
    .flags     (flags),
    .char_code (char_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_char.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_scan.scan_byte;
    end
    if (s1_fire) begin
      out_char_r <= char_nxt;
    end
  end

  assign out_char.valid     = out_valid_r;
  assign out_char.char_code = out_char_r;

  `SC2C_ASSERT_NEXT(a_break_no_char, s1_fire && s1_byte_r[BreakBit], out_char_r == NO_CHAR)
  `SC2C_ASSERT_NOW(a_empty_ready, !s1_valid_r, in_scan.ready)
  `SC2C_ASSERT_NEXT(a_s1_to_out, s1_fire, out_valid_r)

endmodule

// File: rtl/sc2c_modifiers.sv
`include "scancode_to_char_translator_defines.svh"

module sc2c_modifiers (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  upd_en,
  input  sc2c_pkg::byte_t       scan_byte,
  output sc2c_pkg::sc2c_flags_t flags
);
  import sc2c_pkg::*;

  sc2c_flags_t flags_r;
  sc2c_flags_t flags_nxt;
  idx_t        key;
  logic        is_break;

  assign key      = scan_byte[IdxW-1:0];
  assign is_break = scan_byte[BreakBit];

  always_comb begin
    flags_nxt = flags_r;
    if (is_break) begin
      if (key == KEY_LSHIFT[IdxW-1:0] || key == KEY_RSHIFT[IdxW-1:0]) begin
        flags_nxt.shift = 1'b0;
      end else if (key == KEY_ALT[IdxW-1:0]) begin
        flags_nxt.alt = 1'b0;
      end
    end else if (scan_byte == KEY_LSHIFT || scan_byte == KEY_RSHIFT) begin
      flags_nxt.shift = 1'b1;
    end else if (scan_byte == KEY_CAPS) begin
      flags_nxt.caps = ~flags_r.caps;
    end else if (scan_byte == KEY_ALT) begin
      flags_nxt.alt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (upd_en) begin
      flags_r <= flags_nxt;
    end
  end

  assign flags = flags_r;

  `SC2C_ASSERT_NEXT(a_flags_hold, !upd_en, flags_r == $past(flags_r))
  `SC2C_ASSERT_NEXT(a_caps_toggle, upd_en && scan_byte == KEY_CAPS,
                    flags_r.caps != $past(flags_r.caps))
  `SC2C_ASSERT_NEXT(a_shift_make, upd_en && scan_byte == KEY_LSHIFT, flags_r.shift)

endmodule

// File: rtl/sc2c_xlate.sv
module sc2c_xlate (
  input  sc2c_pkg::byte_t       scan_byte,
  input  sc2c_pkg::sc2c_flags_t flags,
  output sc2c_pkg::byte_t       char_code
);
  import sc2c_pkg::*;

  idx_t  idx;
  byte_t base;
  byte_t shifted;
  byte_t alt_sym;
  logic  letter;
  logic  modifier;
  logic  upper;

  assign idx     = scan_byte[IdxW-1:0];
  assign base    = rom_normal(idx);
  assign shifted = rom_shift(idx);
  assign alt_sym = rom_alt(idx);

  // cedilla behaves like a letter under caps lock
  assign letter   = (base >= LETTER_A && base <= LETTER_Z) || base == CEDILLA_LO;
  assign modifier = scan_byte == KEY_LSHIFT || scan_byte == KEY_RSHIFT ||
                    scan_byte == KEY_ALT || scan_byte == KEY_CAPS;
  assign upper    = letter ? (flags.shift ^ flags.caps) : flags.shift;

  always_comb begin
    priority if (scan_byte[BreakBit] || modifier) begin
      char_code = NO_CHAR;
    end else if (flags.alt && alt_sym != NO_CHAR) begin
      char_code = alt_sym;
    end else if (base == NO_CHAR) begin
      char_code = NO_CHAR;
    end else begin
      char_code = upper ? shifted : base;
    end
  end

endmodule
